>>> design/utrd_pkg.sv
package utrd_pkg;

    localparam int CHUNK_BITS = 8;

    localparam logic [4:0] RADIX_RESET = 5'd10;
    localparam logic [4:0] RADIX_MIN   = 5'd2;
    localparam logic [4:0] RADIX_MAX   = 5'd16;

    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_ALPHA = 7'h37;
    localparam logic [3:0] DEC_LIMIT  = 4'd10;

    typedef logic [2:0] step_t;

    localparam step_t STEP_IDLE  = 3'd0;
    localparam step_t STEP_DIV   = 3'd1;
    localparam step_t STEP_STORE = 3'd2;
    localparam step_t STEP_READ  = 3'd3;
    localparam step_t STEP_EMIT  = 3'd4;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_DIV,
        OP_STORE,
        OP_READ,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_START,
        COND_CHUNK_END,
        COND_DONE,
        COND_ALWAYS,
        COND_PTR_ZERO
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t tgt_true;
        step_t tgt_false;
    } ctl_word_t;

    typedef struct packed {
        logic chunk_end;
        logic done;
        logic ptr_zero;
    } flags_t;

    function automatic ctl_word_t ucode_rom(input step_t step);
        ctl_word_t w;
        case (step)
            STEP_IDLE:  w = '{OP_IDLE,  COND_START,     STEP_DIV,  STEP_IDLE};
            STEP_DIV:   w = '{OP_DIV,   COND_CHUNK_END, STEP_STORE, STEP_DIV};
            STEP_STORE: w = '{OP_STORE, COND_DONE,      STEP_READ, STEP_DIV};
            STEP_READ:  w = '{OP_READ,  COND_ALWAYS,    STEP_EMIT, STEP_EMIT};
            STEP_EMIT:  w = '{OP_EMIT,  COND_PTR_ZERO,  STEP_IDLE, STEP_EMIT};
            default:    w = '{OP_IDLE,  COND_ALWAYS,    STEP_IDLE, STEP_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [6:0] glyph(input logic [3:0] d);
        logic [6:0] c;
        if (d < DEC_LIMIT)
        begin
            c = CHAR_ZERO + {3'b000, d};
        end
        else
        begin
            c = CHAR_ALPHA + {3'b000, d};
        end
        return c;
    endfunction

    function automatic logic [4:0] clamp_radix(input logic [4:0] r);
        logic [4:0] e;
        if (r < RADIX_MIN)
        begin
            e = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            e = RADIX_MAX;
        end
        else
        begin
            e = r;
        end
        return e;
    endfunction

endpackage

>>> design/utrd_seq.sv
module utrd_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  utrd_pkg::flags_t   flags,
    output utrd_pkg::ctl_word_t ctl
);
    import utrd_pkg::*;

    step_t pc_reg;
    step_t pc_next;
    logic  cond_met;

    assign ctl = ucode_rom(pc_reg);

    always_comb
    begin
        case (ctl.cond)
            COND_START:     cond_met = start;
            COND_CHUNK_END: cond_met = flags.chunk_end;
            COND_DONE:      cond_met = flags.done;
            COND_ALWAYS:    cond_met = 1'b1;
            COND_PTR_ZERO:  cond_met = flags.ptr_zero;
            default:        cond_met = 1'b1;
        endcase
        pc_next = cond_met ? ctl.tgt_true : ctl.tgt_false;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> design/utrd_datapath.sv
module utrd_datapath #(
    parameter int MAX_DIGITS = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  utrd_pkg::ctl_word_t ctl,
    input  logic                start,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [4:0]          radix_eff,
    output utrd_pkg::flags_t    flags,
    output logic                digit_strobe,
    output logic [6:0]          digit_char,
    output logic                last_digit
);
    import utrd_pkg::*;

    localparam int CHUNKS  = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int PAD_W   = CHUNKS * CHUNK_BITS;
    localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int IDX_W   = $clog2(MAX_DIGITS);
    localparam int CNT_W   = $clog2(MAX_DIGITS + 1);

    logic [3:0]         mem [MAX_DIGITS];

    logic [4:0]         div_reg;
    logic [PAD_W-1:0]   quo_reg;
    logic [PAD_W-1:0]   quo_next;
    logic [4:0]         rem_reg;
    logic [4:0]         rem_next;
    logic [CHUNK_W-1:0] chunk_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   ptr_reg;
    logic [3:0]         rd_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               rd_en;
    logic               strobe_reg;
    logic [6:0]         char_reg;
    logic               last_reg;

    always_comb
    begin
        logic [4:0]       r;
        logic [PAD_W-1:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < CHUNK_BITS; i++)
        begin
            r = {r[3:0], q[PAD_W-1]};
            q = {q[PAD_W-2:0], 1'b0};
            if (r >= div_reg)
            begin
                r    = r - div_reg;
                q[0] = 1'b1;
            end
        end
        rem_next = r;
        quo_next = q;
    end

    assign flags.chunk_end = (chunk_reg == CHUNK_W'(CHUNKS - 1));
    assign flags.done      = (quo_reg == '0) || (count_reg == CNT_W'(MAX_DIGITS - 1));
    assign flags.ptr_zero  = (ptr_reg == '0);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = ptr_reg - 1'b1;
        case (ctl.op)
            OP_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = IDX_W'(count_reg - 1'b1);
            end
            OP_EMIT:
            begin
                rd_en = (ptr_reg != '0);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_STORE)
        begin
            mem[count_reg[IDX_W-1:0]] <= rem_reg[3:0];
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            OP_IDLE:
            begin
                if (start)
                begin
                    quo_reg <= PAD_W'(value);
                    div_reg <= radix_eff;
                    rem_reg <= '0;
                end
            end
            OP_DIV:
            begin
                quo_reg <= quo_next;
                rem_reg <= rem_next;
            end
            OP_STORE:
            begin
                rem_reg <= '0;
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
        char_reg <= glyph(rd_reg);
        last_reg <= (ptr_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg  <= '0;
            count_reg  <= '0;
            ptr_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= (ctl.op == OP_EMIT);
            case (ctl.op)
                OP_IDLE:
                begin
                    if (start)
                    begin
                        chunk_reg <= '0;
                        count_reg <= '0;
                    end
                end
                OP_DIV:
                begin
                    chunk_reg <= chunk_reg + 1'b1;
                end
                OP_STORE:
                begin
                    chunk_reg <= '0;
                    count_reg <= count_reg + 1'b1;
                end
                OP_READ:
                begin
                    ptr_reg <= IDX_W'(count_reg - 1'b1);
                end
                OP_EMIT:
                begin
                    if (ptr_reg != '0)
                    begin
                        ptr_reg <= ptr_reg - 1'b1;
                    end
                end
                default:
                begin
                    ptr_reg <= ptr_reg;
                end
            endcase
        end
    end

    assign digit_strobe = strobe_reg;
    assign digit_char   = char_reg;
    assign last_digit   = last_reg;

endmodule

>>> design/unsigned_to_radix_digits.sv
// Per digit: divide steps over the ceil(VALUE_BITS/8) chunks of the value, 8 quotient bits
// a cycle, then a store step. After the last digit: a read step, then emit steps that send
// the digits out most significant first.
// Throughput: one value at a time; busy stays high until the final digit step.
// Reset: asynchronous, active low; radix returns to 10, sequencer to idle.
// Digit words appear one per cycle with digit_strobe; the receiver cannot stall.
module unsigned_to_radix_digits #(
    parameter int MAX_DIGITS = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [4:0]            radix,
    output logic                  digit_strobe,
    output logic [6:0]            digit_char,
    output logic                  last_digit
);
    import utrd_pkg::*;

    ctl_word_t  ctl;
    flags_t     flags;
    logic [4:0] radix_reg;

    assign busy      = (ctl.op != OP_IDLE);
    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            radix_reg <= radix;
        end
    end

    utrd_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .ctl   (ctl)
    );

    utrd_datapath #(
        .MAX_DIGITS (MAX_DIGITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .start        (start),
        .value        (value),
        .radix_eff    (clamp_radix(radix_reg)),
        .flags        (flags),
        .digit_strobe (digit_strobe),
        .digit_char   (digit_char),
        .last_digit   (last_digit)
    );

endmodule

>>> design/utrd_checker.sv
module utrd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       digit_strobe,
    input logic [6:0] digit_char,
    input logic       last_digit
);

    // flag any glyph outside '0'..'9' and 'A'..'F'
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_strobe |-> ((digit_char >= 7'h30 && digit_char <= 7'h39) ||
                          (digit_char >= 7'h41 && digit_char <= 7'h46)))
        else $error("digit word outside glyph set");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted value did not raise busy");

    a_more_digits: assert property (@(posedge clk) disable iff (!rst_n)
        digit_strobe && !last_digit |-> busy)
        else $error("busy dropped before final digit word");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        digit_strobe && last_digit |-> !busy)
        else $error("still busy at final digit word");

endmodule

bind unsigned_to_radix_digits utrd_checker u_utrd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .digit_strobe (digit_strobe),
    .digit_char   (digit_char),
    .last_digit   (last_digit)
);
